@@ sv/aabbxf_pkg.sv @@
// Shared widths and pipeline control types for the box transform.
`timescale 1ns / 1ps

package aabbxf_pkg;

    localparam int W_COORD = 32;   // Q16.16 coordinate
    localparam int W_COEF  = 16;   // Q4.12 matrix entry
    localparam int W_ROW   = 3 * W_COEF;
    localparam int W_PROD  = W_COORD + W_COEF;
    localparam int W_SUM   = W_PROD + 2;
    localparam int FRAC_SH = 12;   // Q20.28 -> Q16.16
    localparam int W_RND   = W_SUM - FRAC_SH;
    localparam int N_STAGE = 4;

    typedef logic [2:0][W_COORD-1:0] t_vec3;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

@@ sv/aabbxf_axis.sv @@
// One output axis: products, per-column extremes, sum, rounding, saturation.
`timescale 1ns / 1ps

module aabbxf_axis (
    input  logic                                 i_clk,
    input  aabbxf_pkg::t_stage_en                i_en,
    input  logic [aabbxf_pkg::W_ROW-1:0]         i_row,
    input  logic signed [aabbxf_pkg::W_COORD-1:0] i_shift,
    input  aabbxf_pkg::t_vec3                    i_lo,
    input  aabbxf_pkg::t_vec3                    i_hi,
    output logic signed [aabbxf_pkg::W_COORD-1:0] o_lo,
    output logic signed [aabbxf_pkg::W_COORD-1:0] o_hi,
    output logic                                 o_clip
);

    localparam int WP = aabbxf_pkg::W_PROD;
    localparam int WS = aabbxf_pkg::W_SUM;
    localparam int WR = aabbxf_pkg::W_RND;
    localparam int WC = aabbxf_pkg::W_COORD;
    localparam int FS = aabbxf_pkg::FRAC_SH;

    localparam logic signed [WS-1:0] RND_HALF = WS'(1) <<< (FS - 1);
    localparam logic signed [WR-1:0] SAT_MAX  = WR'((64'sd1 <<< (WC - 1)) - 1);
    localparam logic signed [WR-1:0] SAT_MIN  = -(WR'(64'sd1 <<< (WC - 1)));

    // stage 1: products of each column entry with both box bounds
    logic signed [WP-1:0] r_p_lo [3];
    logic signed [WP-1:0] r_p_hi [3];
    // stage 2: per-column extremes
    logic signed [WP-1:0] r_mn [3];
    logic signed [WP-1:0] r_mx [3];
    // stage 3: exact Q22.28 sums plus rounding bias
    logic signed [WS-1:0] r_s_mn, r_s_mx;
    logic signed [WS-1:0] n_s_mn, n_s_mx;
    // stage 4: saturated results
    logic signed [WC-1:0] r_o_lo, r_o_hi;
    logic                 r_clip;

    logic signed [WR-1:0] w_rnd_mn, w_rnd_mx;
    logic                 w_sat_mn, w_sat_mx;

    function automatic logic signed [WC-1:0] sat_val(input logic signed [WR-1:0] v);
        logic signed [WC-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[WC-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[WC-1:0];
        end else begin
            r = v[WC-1:0];
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            if (i_en.s1) begin
                r_p_lo[j] <= $signed(i_row[j*aabbxf_pkg::W_COEF +: aabbxf_pkg::W_COEF])
                             * $signed(i_lo[j]);
                r_p_hi[j] <= $signed(i_row[j*aabbxf_pkg::W_COEF +: aabbxf_pkg::W_COEF])
                             * $signed(i_hi[j]);
            end
            if (i_en.s2) begin
                // the box is separable: each corner extreme is a sum of per-term extremes
                if (r_p_lo[j] < r_p_hi[j]) begin
                    r_mn[j] <= r_p_lo[j];
                    r_mx[j] <= r_p_hi[j];
                end else begin
                    r_mn[j] <= r_p_hi[j];
                    r_mx[j] <= r_p_lo[j];
                end
            end
        end
    end

    always_comb begin
        n_s_mn = WS'(r_mn[0]) + WS'(r_mn[1]) + WS'(r_mn[2])
               + (WS'(i_shift) <<< FS) + RND_HALF;
        n_s_mx = WS'(r_mx[0]) + WS'(r_mx[1]) + WS'(r_mx[2])
               + (WS'(i_shift) <<< FS) + RND_HALF;
    end

    // flooring shift keeps rounding monotone, so extremes survive it
    assign w_rnd_mn = r_s_mn[WS-1:FS];
    assign w_rnd_mx = r_s_mx[WS-1:FS];
    assign w_sat_mn = (w_rnd_mn > SAT_MAX) || (w_rnd_mn < SAT_MIN);
    assign w_sat_mx = (w_rnd_mx > SAT_MAX) || (w_rnd_mx < SAT_MIN);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s_mn <= n_s_mn;
            r_s_mx <= n_s_mx;
        end
        if (i_en.s4) begin
            r_o_lo <= sat_val(w_rnd_mn);
            r_o_hi <= sat_val(w_rnd_mx);
            r_clip <= w_sat_mn || w_sat_mx;
        end
    end

    assign o_lo   = r_o_lo;
    assign o_hi   = r_o_hi;
    assign o_clip = r_clip;

endmodule

@@ sv/aabb_affine_transform.sv @@
// Top level: affine transform of an axis-aligned box, register file and pipeline control.
`timescale 1ns / 1ps
//
// Input channel (i_in_valid / o_in_ready) takes one box per beat as min and
// max corners in signed Q16.16. Output channel (o_out_valid / i_out_ready)
// returns the enclosing box of the eight transformed corners plus a clipped
// flag, one result per input beat, in order.
// The matrix and translation come from a plain write port (i_cfg_we,
// i_cfg_index, i_cfg_data); write it only while the pipeline is empty.
// The four-stage pipeline registers each box through multiply, per-column
// min/max, three-term sum with translation, and round and saturate;
// o_out_valid rises when the box reaches the last stage. Throughput is one
// box per cycle while the receiver keeps i_out_ready high.
// Each stage holds its own valid bit and loads when it is empty or the stage
// after it moves, so a stalled receiver holds the last stage while bubbles
// ahead of it still fill; o_in_ready drops only when all four stages are full.
// Synchronous reset empties the pipeline and loads the identity matrix with
// zero translation.
//
module aabb_affine_transform (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [aabbxf_pkg::W_COORD-1:0] i_lo_x,
    input  logic signed [aabbxf_pkg::W_COORD-1:0] i_lo_y,
    input  logic signed [aabbxf_pkg::W_COORD-1:0] i_lo_z,
    input  logic signed [aabbxf_pkg::W_COORD-1:0] i_hi_x,
    input  logic signed [aabbxf_pkg::W_COORD-1:0] i_hi_y,
    input  logic signed [aabbxf_pkg::W_COORD-1:0] i_hi_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [aabbxf_pkg::W_COORD-1:0] o_out_lo_x,
    output logic signed [aabbxf_pkg::W_COORD-1:0] o_out_lo_y,
    output logic signed [aabbxf_pkg::W_COORD-1:0] o_out_lo_z,
    output logic signed [aabbxf_pkg::W_COORD-1:0] o_out_hi_x,
    output logic signed [aabbxf_pkg::W_COORD-1:0] o_out_hi_y,
    output logic signed [aabbxf_pkg::W_COORD-1:0] o_out_hi_z,
    output logic                                  o_clipped,
    input  logic                                  i_cfg_we,
    input  logic [2:0]                            i_cfg_index,
    input  logic [aabbxf_pkg::W_ROW-1:0]          i_cfg_data
);

    localparam int WC = aabbxf_pkg::W_COORD;
    localparam int WW = aabbxf_pkg::W_ROW;
    localparam int NS = aabbxf_pkg::N_STAGE;

    localparam logic [2:0] REG_ROW_X   = 3'd0;
    localparam logic [2:0] REG_ROW_Y   = 3'd1;
    localparam logic [2:0] REG_ROW_Z   = 3'd2;
    localparam logic [2:0] REG_SHIFT_X = 3'd3;
    localparam logic [2:0] REG_SHIFT_Y = 3'd4;
    localparam logic [2:0] REG_SHIFT_Z = 3'd5;

    // identity in Q4.12
    localparam logic [WW-1:0] ROW_X_RST = WW'(48'h0000_0000_1000);
    localparam logic [WW-1:0] ROW_Y_RST = WW'(48'h0000_1000_0000);
    localparam logic [WW-1:0] ROW_Z_RST = WW'(48'h1000_0000_0000);

    logic [WW-1:0]        r_row_x, r_row_y, r_row_z;
    logic signed [WC-1:0] r_shift_x, r_shift_y, r_shift_z;

    logic [NS-1:0]         r_v;
    logic [NS-1:0]         w_rdy;
    aabbxf_pkg::t_stage_en w_en;
    aabbxf_pkg::t_vec3     w_lo, w_hi;
    logic [2:0]            w_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x   <= ROW_X_RST;
            r_row_y   <= ROW_Y_RST;
            r_row_z   <= ROW_Z_RST;
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_shift_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW_X:   r_row_x   <= i_cfg_data;
                REG_ROW_Y:   r_row_y   <= i_cfg_data;
                REG_ROW_Z:   r_row_z   <= i_cfg_data;
                REG_SHIFT_X: r_shift_x <= i_cfg_data[WC-1:0];
                REG_SHIFT_Y: r_shift_y <= i_cfg_data[WC-1:0];
                REG_SHIFT_Z: r_shift_z <= i_cfg_data[WC-1:0];
                default: ;
            endcase
        end
    end

    // a stage may load when empty or when its contents move on
    assign w_rdy[3] = !r_v[3] || i_out_ready;
    assign w_rdy[2] = !r_v[2] || w_rdy[3];
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];

    assign w_en.s1 = w_rdy[0];
    assign w_en.s2 = w_rdy[1];
    assign w_en.s3 = w_rdy[2];
    assign w_en.s4 = w_rdy[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_in_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
            if (w_rdy[3]) r_v[3] <= r_v[2];
        end
    end

    assign w_lo = {i_lo_z, i_lo_y, i_lo_x};
    assign w_hi = {i_hi_z, i_hi_y, i_hi_x};

    aabbxf_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_row   (r_row_x),
        .i_shift (r_shift_x),
        .i_lo    (w_lo),
        .i_hi    (w_hi),
        .o_lo    (o_out_lo_x),
        .o_hi    (o_out_hi_x),
        .o_clip  (w_clip[0])
    );

    aabbxf_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_row   (r_row_y),
        .i_shift (r_shift_y),
        .i_lo    (w_lo),
        .i_hi    (w_hi),
        .o_lo    (o_out_lo_y),
        .o_hi    (o_out_hi_y),
        .o_clip  (w_clip[1])
    );

    aabbxf_axis u_axis_z (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_row   (r_row_z),
        .i_shift (r_shift_z),
        .i_lo    (w_lo),
        .i_hi    (w_hi),
        .o_lo    (o_out_lo_z),
        .o_hi    (o_out_hi_z),
        .o_clip  (w_clip[2])
    );

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_v[3];
    assign o_clipped   = |w_clip;

    // results never come out inverted
    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_lo_x <= o_out_hi_x) && (o_out_lo_y <= o_out_hi_y)
                        && (o_out_lo_z <= o_out_hi_z))
        else $error("output box inverted");

    // back-pressure only when every stage holds a beat
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v == {NS{1'b1}}))
        else $error("input stalled with a bubble in the pipeline");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v[0])
        else $error("accepted beat missing from first stage");

    // clipped implies some output sits on a rail
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            (o_out_lo_x == 32'sh7fffffff) || (o_out_lo_x == 32'sh80000000) ||
            (o_out_lo_y == 32'sh7fffffff) || (o_out_lo_y == 32'sh80000000) ||
            (o_out_lo_z == 32'sh7fffffff) || (o_out_lo_z == 32'sh80000000) ||
            (o_out_hi_x == 32'sh7fffffff) || (o_out_hi_x == 32'sh80000000) ||
            (o_out_hi_y == 32'sh7fffffff) || (o_out_hi_y == 32'sh80000000) ||
            (o_out_hi_z == 32'sh7fffffff) || (o_out_hi_z == 32'sh80000000))
        else $error("clipped set with no saturated output");

endmodule

@@ tb/aabb_affine_transform_checker.sv @@
// Box transform checker: shared testbench types, result prediction and beat comparison.
`timescale 1ns / 1ps

package aabbxf_tb_pkg;

    typedef enum logic [2:0] {
        REG_ROW_X   = 3'd0,
        REG_ROW_Y   = 3'd1,
        REG_ROW_Z   = 3'd2,
        REG_SHIFT_X = 3'd3,
        REG_SHIFT_Y = 3'd4,
        REG_SHIFT_Z = 3'd5,
        REG_SPARE_6 = 3'd6,
        REG_SPARE_7 = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic signed [31:0] lo_x;
        logic signed [31:0] lo_y;
        logic signed [31:0] lo_z;
        logic signed [31:0] hi_x;
        logic signed [31:0] hi_y;
        logic signed [31:0] hi_z;
    } t_box;

    typedef struct packed {
        logic signed [31:0] lo_x;
        logic signed [31:0] lo_y;
        logic signed [31:0] lo_z;
        logic signed [31:0] hi_x;
        logic signed [31:0] hi_y;
        logic signed [31:0] hi_z;
        logic               clipped;
    } t_bounds;

endpackage

module aabb_affine_transform_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  aabbxf_tb_pkg::t_box    i_box,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  aabbxf_tb_pkg::t_bounds i_bounds,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [47:0]            i_cfg_data,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_saturated
);

    localparam longint COEF_ONE   = 4096;   // Q4.12 one, also Q16.16 -> Q20.28 scale
    localparam longint ROUND_HALF = 2048;
    localparam int     FRAC_BITS  = 12;
    localparam longint COORD_MAX  = (longint'(1) << 31) - 1;
    localparam longint COORD_MIN  = -(longint'(1) << 31);

    logic [47:0]            coef_row [3];
    logic signed [31:0]     offset   [3];
    aabbxf_tb_pkg::t_bounds bounds_q [$];

    // one output coordinate, rounded half up to Q16.16, not yet clamped
    function automatic longint axis_coord(logic [47:0] row, logic signed [31:0] shift,
                                          longint p0, longint p1, longint p2);
        logic signed [15:0] m0;
        logic signed [15:0] m1;
        logic signed [15:0] m2;
        longint             acc;
        m0  = row[15:0];
        m1  = row[31:16];
        m2  = row[47:32];
        acc = longint'(m0) * p0 + longint'(m1) * p1 + longint'(m2) * p2
            + longint'(shift) * COEF_ONE;
        return (acc + ROUND_HALF) >>> FRAC_BITS;
    endfunction

    function automatic logic [31:0] clamp_q16(longint v, inout bit sat);
        if (v > COORD_MAX) begin
            sat = 1'b1;
            return COORD_MAX[31:0];
        end
        if (v < COORD_MIN) begin
            sat = 1'b1;
            return COORD_MIN[31:0];
        end
        return v[31:0];
    endfunction

    // enclosing box of all eight transformed corners
    function automatic aabbxf_tb_pkg::t_bounds predict_bounds(aabbxf_tb_pkg::t_box b);
        longint                 lo [3];
        longint                 hi [3];
        longint                 p  [3];
        longint                 mn [3];
        longint                 mx [3];
        longint                 v;
        bit                     sat;
        aabbxf_tb_pkg::t_bounds r;
        lo[0] = b.lo_x;
        lo[1] = b.lo_y;
        lo[2] = b.lo_z;
        hi[0] = b.hi_x;
        hi[1] = b.hi_y;
        hi[2] = b.hi_z;
        sat   = 1'b0;
        for (int c = 0; c < 8; c++) begin
            p[0] = c[0] ? hi[0] : lo[0];
            p[1] = c[1] ? hi[1] : lo[1];
            p[2] = c[2] ? hi[2] : lo[2];
            for (int a = 0; a < 3; a++) begin
                v = axis_coord(coef_row[a], offset[a], p[0], p[1], p[2]);
                if (c == 0 || v < mn[a]) mn[a] = v;
                if (c == 0 || v > mx[a]) mx[a] = v;
            end
        end
        r.lo_x    = clamp_q16(mn[0], sat);
        r.lo_y    = clamp_q16(mn[1], sat);
        r.lo_z    = clamp_q16(mn[2], sat);
        r.hi_x    = clamp_q16(mx[0], sat);
        r.hi_y    = clamp_q16(mx[1], sat);
        r.hi_z    = clamp_q16(mx[2], sat);
        r.clipped = sat;
        return r;
    endfunction

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        aabbxf_tb_pkg::t_bounds want;
        int                     bad;
        if (!i_rst_n) begin
            coef_row[0] = {16'h0000, 16'h0000, 16'h1000};
            coef_row[1] = {16'h0000, 16'h1000, 16'h0000};
            coef_row[2] = {16'h1000, 16'h0000, 16'h0000};
            offset[0]   = '0;
            offset[1]   = '0;
            offset[2]   = '0;
            bounds_q.delete();
            o_errors    = 0;
            o_checked   = 0;
            o_saturated = 0;
        end else begin
            // pop before push: a result beat always belongs to an earlier box
            if (i_out_valid && i_out_ready) begin
                if (bounds_q.size() == 0) begin
                    $error("result beat with no box outstanding");
                    o_errors++;
                end else begin
                    want = bounds_q.pop_front();
                    bad  = 0;
                    bad += field_diff("out_lo_x", want.lo_x, i_bounds.lo_x);
                    bad += field_diff("out_lo_y", want.lo_y, i_bounds.lo_y);
                    bad += field_diff("out_lo_z", want.lo_z, i_bounds.lo_z);
                    bad += field_diff("out_hi_x", want.hi_x, i_bounds.hi_x);
                    bad += field_diff("out_hi_y", want.hi_y, i_bounds.hi_y);
                    bad += field_diff("out_hi_z", want.hi_z, i_bounds.hi_z);
                    bad += field_diff("clipped", 32'(want.clipped), 32'(i_bounds.clipped));
                    o_errors += bad;
                    o_checked++;
                    if (want.clipped) o_saturated++;
                end
            end
            if (i_in_valid && i_in_ready) bounds_q.push_back(predict_bounds(i_box));
            if (i_cfg_we) begin
                case (aabbxf_tb_pkg::t_reg_index'(i_cfg_index))
                    aabbxf_tb_pkg::REG_ROW_X:   coef_row[0] = i_cfg_data;
                    aabbxf_tb_pkg::REG_ROW_Y:   coef_row[1] = i_cfg_data;
                    aabbxf_tb_pkg::REG_ROW_Z:   coef_row[2] = i_cfg_data;
                    aabbxf_tb_pkg::REG_SHIFT_X: offset[0]   = i_cfg_data[31:0];
                    aabbxf_tb_pkg::REG_SHIFT_Y: offset[1]   = i_cfg_data[31:0];
                    aabbxf_tb_pkg::REG_SHIFT_Z: offset[2]   = i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
        o_pending = bounds_q.size();
    end

endmodule

@@ tb/tb_aabb_affine_transform.sv @@
// Testbench top for the box transform: clock, reset, box and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_aabb_affine_transform;

    localparam int N_SETTINGS        = 9;
    localparam int N_DIRECTED        = 12;
    localparam int ITEMS_PER_SETTING = 205;
    localparam int IDLE_PCT          = 38;
    localparam int DRAIN_CYCLES      = 8;
    localparam int CYCLE_LIMIT       = 200000;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    aabbxf_tb_pkg::t_box       in_box    = '0;
    logic                      out_ready = 1'b0;
    logic                      cfg_we    = 1'b0;
    aabbxf_tb_pkg::t_reg_index cfg_index = aabbxf_tb_pkg::REG_ROW_X;
    logic [47:0]               cfg_data  = '0;
    bit                        calm      = 1'b0;
    int                        boxes_sent = 0;
    int                        cycle_count = 0;

    logic               in_ready;
    logic               out_valid;
    logic signed [31:0] out_lo_x, out_lo_y, out_lo_z;
    logic signed [31:0] out_hi_x, out_hi_y, out_hi_z;
    logic               out_clipped;

    int errors, pending, checked, saturated;

    always #2 clk = ~clk;

    aabb_affine_transform i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_lo_x      (in_box.lo_x),
        .i_lo_y      (in_box.lo_y),
        .i_lo_z      (in_box.lo_z),
        .i_hi_x      (in_box.hi_x),
        .i_hi_y      (in_box.hi_y),
        .i_hi_z      (in_box.hi_z),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_lo_x  (out_lo_x),
        .o_out_lo_y  (out_lo_y),
        .o_out_lo_z  (out_lo_z),
        .o_out_hi_x  (out_hi_x),
        .o_out_hi_y  (out_hi_y),
        .o_out_hi_z  (out_hi_z),
        .o_clipped   (out_clipped),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    aabb_affine_transform_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_box       (in_box),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_bounds    ({out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z,
                       out_clipped}),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_saturated (saturated)
    );

    always @(negedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("** aabb_affine_transform: FAILED **");
            $finish;
        end
    end

    function automatic logic [47:0] pack_row(logic [15:0] m0, logic [15:0] m1,
                                             logic [15:0] m2);
        return {m2, m1, m0};
    endfunction

    // upper bits of a shift write are don't-care, so fill them with noise
    function automatic logic [47:0] shift_word(logic [31:0] s);
        return {16'($urandom_range(16'hFFFF)), s};
    endfunction

    function automatic logic [15:0] rand_unit_coef();
        return 16'($urandom_range(16'h2000)) - 16'h1000;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            4, 5:    return 32'($urandom_range(20'hFFFFF)) - 32'h0008_0000;
            6, 7:    return 32'($urandom_range(32'h01FF_FFFF)) - 32'h0100_0000;
            8:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            9:       return 32'($urandom_range(2)) - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // mostly ordered boxes: an axis drawn inverted stays so about one time in five
    function automatic aabbxf_tb_pkg::t_box rand_box();
        logic signed [31:0]  a [3];
        logic signed [31:0]  b [3];
        logic signed [31:0]  t;
        aabbxf_tb_pkg::t_box r;
        for (int i = 0; i < 3; i++) begin
            a[i] = rand_coord();
            b[i] = rand_coord();
            if ($urandom_range(99) < 80 && a[i] > b[i]) begin
                t    = a[i];
                a[i] = b[i];
                b[i] = t;
            end
        end
        r = '{a[0], a[1], a[2], b[0], b[1], b[2]};
        return r;
    endfunction

    function automatic aabbxf_tb_pkg::t_box directed_box(int n);
        case (n)
            0:  return '0;
            1:  return '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
            2:  return '{6{32'h7FFF_FFFF}};
            3:  return '{6{32'h8000_0000}};
            4:  return '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                         32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFD_0000};
            5:  return '{32'd1, 32'd1, 32'd1, 32'd3, 32'd3, 32'd3};
            6:  return '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFD, 32'hFFFF_FFFD, 32'hFFFF_FFFD};
            7:  return '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'd1, 32'd1, 32'd1};
            8:  return '{32'h8000_0000, 32'd0, 32'hFFFF_FFFF,
                         32'd0, 32'h7FFF_FFFF, 32'd1};
            9:  return '{32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000,
                         32'h8001_0000, 32'h8001_0000, 32'h8001_0000};
            10: return '{32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                         32'h5555_5555, 32'h5555_5555, 32'h5555_5555};
            default: return '{32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                              32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA};
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_box(aabbxf_tb_pkg::t_box b);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_box   <= b;
        do @(posedge clk); while (!in_ready);
        boxes_sent++;
        @(negedge clk);
    endtask

    // hold the sender until every predicted result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic apply_setting(int k);
        logic [47:0] regs [8];
        case (k)
            1: begin
                // half coefficients give exact rounding ties on odd inputs
                regs[aabbxf_tb_pkg::REG_ROW_X]   = pack_row(16'h0800, 16'h0000, 16'h0000);
                regs[aabbxf_tb_pkg::REG_ROW_Y]   = pack_row(16'h0000, 16'h8000, 16'h0800);
                regs[aabbxf_tb_pkg::REG_ROW_Z]   = pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF);
                regs[aabbxf_tb_pkg::REG_SHIFT_X] = shift_word(32'h7FFF_FFFF);
                regs[aabbxf_tb_pkg::REG_SHIFT_Y] = shift_word(32'h8000_0000);
                regs[aabbxf_tb_pkg::REG_SHIFT_Z] = shift_word(32'h0000_0000);
            end
            2: begin
                for (int i = aabbxf_tb_pkg::REG_ROW_X; i <= aabbxf_tb_pkg::REG_ROW_Z; i++)
                    regs[i] = pack_row(16'h8000, 16'h8000, 16'h8000);
                for (int i = aabbxf_tb_pkg::REG_SHIFT_X; i <= aabbxf_tb_pkg::REG_SHIFT_Z; i++)
                    regs[i] = shift_word(32'h8000_0000);
            end
            3: begin
                for (int i = aabbxf_tb_pkg::REG_ROW_X; i <= aabbxf_tb_pkg::REG_ROW_Z; i++)
                    regs[i] = pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF);
                for (int i = aabbxf_tb_pkg::REG_SHIFT_X; i <= aabbxf_tb_pkg::REG_SHIFT_Z; i++)
                    regs[i] = shift_word(32'h7FFF_FFFF);
            end
            4: begin
                for (int i = aabbxf_tb_pkg::REG_ROW_X; i <= aabbxf_tb_pkg::REG_ROW_Z; i++)
                    regs[i] = '0;
                for (int i = aabbxf_tb_pkg::REG_SHIFT_X; i <= aabbxf_tb_pkg::REG_SHIFT_Z; i++)
                    regs[i] = shift_word($urandom);
            end
            5: begin
                for (int i = aabbxf_tb_pkg::REG_ROW_X; i <= aabbxf_tb_pkg::REG_ROW_Z; i++)
                    regs[i] = pack_row(rand_unit_coef(), rand_unit_coef(), rand_unit_coef());
                for (int i = aabbxf_tb_pkg::REG_SHIFT_X; i <= aabbxf_tb_pkg::REG_SHIFT_Z; i++)
                    regs[i] = shift_word(32'($urandom_range(32'h00FF_FFFF)) - 32'h0080_0000);
            end
            7: begin
                regs[aabbxf_tb_pkg::REG_ROW_X] = pack_row(16'h1000, 16'h0000, 16'h0000);
                regs[aabbxf_tb_pkg::REG_ROW_Y] = pack_row(16'h0000, 16'h1000, 16'h0000);
                regs[aabbxf_tb_pkg::REG_ROW_Z] = pack_row(16'h0000, 16'h0000, 16'h1000);
                for (int i = aabbxf_tb_pkg::REG_SHIFT_X; i <= aabbxf_tb_pkg::REG_SHIFT_Z; i++)
                    regs[i] = shift_word($urandom);
            end
            default: begin
                for (int i = aabbxf_tb_pkg::REG_ROW_X; i <= aabbxf_tb_pkg::REG_ROW_Z; i++)
                    regs[i] = {16'($urandom_range(16'hFFFF)), 32'($urandom)};
                for (int i = aabbxf_tb_pkg::REG_SHIFT_X; i <= aabbxf_tb_pkg::REG_SHIFT_Z; i++)
                    regs[i] = shift_word($urandom);
            end
        endcase
        // spare indexes last, so an aliased decode would clobber a live register
        regs[aabbxf_tb_pkg::REG_SPARE_6] = {16'($urandom_range(16'hFFFF)), 32'($urandom)};
        regs[aabbxf_tb_pkg::REG_SPARE_7] = {16'($urandom_range(16'hFFFF)), 32'($urandom)};
        for (int i = aabbxf_tb_pkg::REG_ROW_X; i <= aabbxf_tb_pkg::REG_SPARE_7; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= aabbxf_tb_pkg::t_reg_index'(i);
            cfg_data  <= regs[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int k = 0; k < N_SETTINGS; k++) begin
            if (k > 0) begin
                drain_results();
                apply_setting(k);
            end
            calm = (k == 5);
            if (k < 2) begin
                for (int n = 0; n < N_DIRECTED; n++)
                    send_box(directed_box(n));
            end
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                if (k == 3 && n == ITEMS_PER_SETTING / 2) drain_results();
                send_box(rand_box());
            end
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending != 0) $error("%0d expected results never arrived", pending);
        $display("Sent %0d boxes across %0d matrix settings (identity, extreme, random).",
                 boxes_sent, N_SETTINGS);
        $display("Checked %0d results, %0d of them saturated.", checked, saturated);
        if (errors == 0 && pending == 0) begin
            $display("** aabb_affine_transform: PASSED **");
        end else begin
            $display("** aabb_affine_transform: FAILED **");
        end
        $finish;
    end

endmodule

@@ aabb_affine_transform.f @@
sv/aabbxf_pkg.sv
sv/aabbxf_axis.sv
sv/aabb_affine_transform.sv
tb/aabb_affine_transform_checker.sv
tb/tb_aabb_affine_transform.sv
